[rtl/ede_pkg.sv]
package ede_pkg;

   // Width of the symbol field on the request channel
   localparam int SYMBOL_FIELD_BITS = 24;
   // Width of the distance field on the response channel
   localparam int DISTANCE_BITS = 7;

   // Request opcodes
   localparam logic OP_QUERY     = 1'b0;
   localparam logic OP_CANDIDATE = 1'b1;

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CELL = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   typedef struct packed {
      logic                         opcode;
      logic [SYMBOL_FIELD_BITS-1:0] symbol;
      logic                         last;
   } req_payload_type;

   typedef struct packed {
      logic [DISTANCE_BITS-1:0] distance;
      logic                     too_long;
   } rsp_payload_type;

endpackage

[rtl/ede_ram.sv]
module ede_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/ede_cell_unit.sv]
module ede_cell_unit #(
   parameter int CW = 7,
   parameter int SW = 24
) (
   input  logic          first,
   input  logic [CW-1:0] count,
   input  logic [CW-1:0] above,
   input  logic [CW-1:0] left,
   input  logic [CW-1:0] diag,
   input  logic [SW-1:0] qsym,
   input  logic [SW-1:0] sym,
   output logic [CW-1:0] new_cost
);

   logic          sub;
   logic [CW:0]   del_cost;
   logic [CW:0]   ins_cost;
   logic [CW:0]   sub_cost;
   logic [CW:0]   min_ab;
   logic [CW:0]   min_all;

   // Three candidate costs, one extra bit for the +1
   assign sub      = (qsym != sym);
   assign del_cost = {1'b0, above} + (CW+1)'(1);
   assign ins_cost = {1'b0, left} + (CW+1)'(1);
   assign sub_cost = {1'b0, diag} + (CW+1)'(sub);

   assign min_ab  = (del_cost < ins_cost) ? del_cost : ins_cost;
   assign min_all = (min_ab < sub_cost) ? min_ab : sub_cost;

   // Column zero of the row holds the count of candidate symbols so far
   assign new_cost = first ? count : min_all[CW-1:0];

endmodule

[rtl/edit_distance_engine.sv]
// Levenshtein edit distance engine.
// Request channel (req_valid/req_ready/req_payload): opcode 0 appends a
// symbol to the stored query, opcode 1 feeds one candidate symbol; last
// marks the final symbol of a word. The first query symbol after a
// completed query starts a new query.
// Response channel (rsp_valid/rsp_ready/rsp_payload): one transfer per
// candidate word, carrying the distance and a too_long flag.
// Sequence: a query symbol is absorbed in the idle state. A candidate
// symbol is accepted, then processed one row entry per cycle through
// the shared cell unit and the cost row memory. A final candidate
// symbol then loads the response register. Dropped candidate symbols
// skip the row update.
// req_ready is low while a row update runs.
// Stalls: the response register holds a result until it is taken while
// new requests keep being accepted; a second result waits in the engine
// (req_ready low) until the register frees up.
// Reset clears all word state; the query and cost row memories need no
// clearing, as entries are always written before they are read.
module edit_distance_engine #(
   parameter int MAX_LEN     = 64,
   parameter int SYMBOL_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ede_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ede_pkg::rsp_payload_type rsp_payload
);

   localparam int SW  = (SYMBOL_BITS < ede_pkg::SYMBOL_FIELD_BITS) ?
                        SYMBOL_BITS : ede_pkg::SYMBOL_FIELD_BITS;
   localparam int CW  = $clog2(MAX_LEN + 1);
   localparam int QAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   // Control state
   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] qlen_ff, qlen_in;
   logic          qdone_ff, qdone_in;
   logic          ovf_ff, ovf_in;
   logic          active_ff, active_in;
   logic          cdrop_ff, cdrop_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Datapath state
   logic          fresh_ff, fresh_in;
   logic          last_ff, last_in;
   logic [SW-1:0] sym_ff, sym_in;
   logic [CW-1:0] left_ff, left_in;
   logic [CW-1:0] diag_ff, diag_in;
   logic [CW-1:0] final_ff, final_in;
   logic [CW-1:0] res_dist_ff, res_dist_in;
   logic          res_long_ff, res_long_in;
   ede_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          is_query;
   logic [CW-1:0] eff_len;
   logic          cand_drop;
   logic          rsp_free;
   logic          cell_done;
   logic [CW-1:0] cell_above;
   logic [CW-1:0] new_cost;
   logic [CW+6:0] dist_wide;

   logic          q_wr_en;
   logic [QAW-1:0] q_wr_addr;
   logic [QAW-1:0] q_rd_addr;
   logic [SW-1:0]  q_rd_data;
   logic          row_wr_en;
   logic [CW-1:0] row_rd_addr;
   logic [CW-1:0] row_rd_data;

   assign req_ready   = (state_ff == ede_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign accept    = req_valid & req_ready;
   assign is_query  = (req_payload.opcode == ede_pkg::OP_QUERY);
   assign eff_len   = qdone_ff ? '0 : qlen_ff;
   assign cand_drop = active_ff && (count_ff == CW'(MAX_LEN));
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign cell_done = (idx_ff == qlen_ff);
   assign cell_above = fresh_ff ? idx_ff : row_rd_data;
   assign dist_wide = {7'd0, res_dist_ff};

   // Memory ports
   assign q_wr_en     = accept && is_query && (eff_len < CW'(MAX_LEN));
   assign q_wr_addr   = eff_len[QAW-1:0];
   assign row_wr_en   = (state_ff == ede_pkg::ST_CELL);
   assign row_rd_addr = (state_ff == ede_pkg::ST_CELL && !cell_done) ?
                        idx_ff + CW'(1) : '0;
   assign q_rd_addr   = (state_ff == ede_pkg::ST_CELL && !cell_done) ?
                        idx_ff[QAW-1:0] : '0;

   ede_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_LEN),
      .AW    (QAW)
   ) u_query_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (req_payload.symbol[SW-1:0]),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   ede_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_LEN + 1),
      .AW    (CW)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (idx_ff),
      .wr_data (new_cost),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data)
   );

   ede_cell_unit #(
      .CW (CW),
      .SW (SW)
   ) u_cell (
      .first    (idx_ff == '0),
      .count    (count_ff),
      .above    (cell_above),
      .left     (left_ff),
      .diag     (diag_ff),
      .qsym     (q_rd_data),
      .sym      (sym_ff),
      .new_cost (new_cost)
   );

   // Sequencer and word bookkeeping
   always_comb begin
      state_in     = state_ff;
      qlen_in      = qlen_ff;
      qdone_in     = qdone_ff;
      ovf_in       = ovf_ff;
      active_in    = active_ff;
      cdrop_in     = cdrop_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      fresh_in     = fresh_ff;
      last_in      = last_ff;
      sym_in       = sym_ff;
      left_in      = left_ff;
      diag_in      = diag_ff;
      final_in     = final_ff;
      res_dist_in  = res_dist_ff;
      res_long_in  = res_long_ff;
      rsp_data_in  = rsp_data_ff;

      // Response register drains independently
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ede_pkg::ST_IDLE: begin
            if (accept && is_query) begin
               // Query symbol: abandon any candidate, append or drop
               active_in = 1'b0;
               cdrop_in  = 1'b0;
               if (qdone_ff) begin
                  qdone_in = 1'b0;
                  ovf_in   = 1'b0;
               end
               if (eff_len < CW'(MAX_LEN)) begin
                  qlen_in = eff_len + CW'(1);
               end else begin
                  qlen_in = eff_len;
                  ovf_in  = 1'b1;
               end
               if (req_payload.last) begin
                  qdone_in = 1'b1;
               end
            end else if (accept) begin
               // Candidate symbol
               active_in   = !req_payload.last;
               res_long_in = ovf_ff || cand_drop || (active_ff && cdrop_ff);
               if (req_payload.last) begin
                  cdrop_in = 1'b0;
               end else begin
                  cdrop_in = cand_drop || (active_ff && cdrop_ff);
               end
               if (cand_drop) begin
                  res_dist_in = final_ff;
                  if (req_payload.last) begin
                     state_in = ede_pkg::ST_FIN;
                  end
               end else begin
                  fresh_in = !active_ff;
                  last_in  = req_payload.last;
                  sym_in   = req_payload.symbol[SW-1:0];
                  count_in = (active_ff ? count_ff : '0) + CW'(1);
                  idx_in   = '0;
                  state_in = ede_pkg::ST_CELL;
               end
            end
         end
         ede_pkg::ST_CELL: begin
            // One row entry per cycle through the shared cell unit
            left_in = new_cost;
            diag_in = cell_above;
            if (cell_done) begin
               final_in    = new_cost;
               res_dist_in = new_cost;
               state_in    = last_ff ? ede_pkg::ST_FIN : ede_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ede_pkg::ST_FIN: begin
            // Load the response register once it is free
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.distance = dist_wide[ede_pkg::DISTANCE_BITS-1:0];
               rsp_data_in.too_long = res_long_ff;
               state_in             = ede_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ede_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ede_pkg::ST_IDLE;
         qlen_ff      <= '0;
         qdone_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         active_ff    <= 1'b0;
         cdrop_ff     <= 1'b0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         qlen_ff      <= qlen_in;
         qdone_ff     <= qdone_in;
         ovf_ff       <= ovf_in;
         active_ff    <= active_in;
         cdrop_ff     <= cdrop_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      fresh_ff    <= fresh_in;
      last_ff     <= last_in;
      sym_ff      <= sym_in;
      left_ff     <= left_in;
      diag_ff     <= diag_in;
      final_ff    <= final_in;
      res_dist_ff <= res_dist_in;
      res_long_ff <= res_long_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[rtl/ede_checker.sv]
module ede_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input ede_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input ede_pkg::rsp_payload_type rsp_payload
);

   // A stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // Reset empties the response register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A query symbol leaves the engine ready again in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.opcode == ede_pkg::OP_QUERY
      |=> req_ready)
      else $error("engine busy after query symbol");

   // Only the last symbol of a candidate can start a new response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_payload.last |=> !$rose(rsp_valid))
      else $error("response raised without a final candidate symbol");

endmodule

bind edit_distance_engine ede_checker u_ede_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;

   localparam int MAX_LEN = 64;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   ede_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   ede_pkg::rsp_payload_type rsp_payload;

   edit_distance_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   // Symbols waiting to be sent, and distances waiting to come back
   ede_pkg::req_payload_type symbol_feed[$];
   ede_pkg::rsp_payload_type pending_distances[$];
   int              n_items = 0;
   int              accepted = 0;
   int              failures = 0;
   logic [23:0]     alphabet[6];

   // Shadow of the engine's word state
   logic [23:0] query_sym[MAX_LEN];
   int          query_len = 0;
   bit          query_done = 1'b0;
   bit          query_over = 1'b0;
   int          cost[0:MAX_LEN];
   int          cand_len = 0;
   bit          cand_open = 1'b0;
   bit          cand_cut = 1'b0;

   // Update the shadow state with one accepted symbol; queue a distance on a word end
   function automatic void track_symbol(ede_pkg::req_payload_type t);
      int                       above;
      int                       diag;
      int                       best;
      ede_pkg::rsp_payload_type r;
      if (t.opcode == ede_pkg::OP_QUERY) begin
         cand_open = 1'b0;
         cand_cut  = 1'b0;
         if (query_done) begin
            query_len  = 0;
            query_done = 1'b0;
            query_over = 1'b0;
         end
         if (query_len < MAX_LEN) begin
            query_sym[query_len] = t.symbol;
            query_len++;
         end else begin
            query_over = 1'b1;
         end
         if (t.last)
            query_done = 1'b1;
      end else begin
         if (!cand_open) begin
            for (int i = 0; i <= query_len; i++)
               cost[i] = i;
            cand_len  = 0;
            cand_open = 1'b1;
            cand_cut  = 1'b0;
         end
         if (cand_len < MAX_LEN) begin
            diag    = cost[0];
            cost[0] = cand_len + 1;
            for (int i = 1; i <= query_len; i++) begin
               above = cost[i];
               best  = diag + ((query_sym[i-1] == t.symbol) ? 0 : 1);
               if (above + 1 < best)
                  best = above + 1;
               if (cost[i-1] + 1 < best)
                  best = cost[i-1] + 1;
               cost[i] = best;
               diag    = above;
            end
            cand_len++;
         end else begin
            cand_cut = 1'b1;
         end
         if (t.last) begin
            r.distance = cost[query_len][6:0];
            r.too_long = query_over | cand_cut;
            pending_distances.insert(pending_distances.size(), r);
            cand_open = 1'b0;
            cand_cut  = 1'b0;
         end
      end
   endfunction

   // Idle rates per phase: sender-light, receiver-light, then flat out
   function automatic int sender_idle_pct(int done);
      if (done < n_items / 3)
         return 18;
      if (done < 2 * n_items / 3)
         return 52;
      return 0;
   endfunction

   function automatic int receiver_idle_pct(int done);
      if (done < n_items / 3)
         return 52;
      if (done < 2 * n_items / 3)
         return 18;
      return 0;
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_symbol(req_payload);
            accepted <= accepted + 1;
         end
         if (!req_valid || req_ready) begin
            if (symbol_feed.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct(accepted)) begin
               req_payload <= symbol_feed.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and checker
   ede_pkg::rsp_payload_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_distances.size() == 0) begin
               $error("unexpected transfer: distance %0d too_long %0b",
                      rsp_payload.distance, rsp_payload.too_long);
               failures++;
            end else begin
               want = pending_distances.pop_front();
               if (rsp_payload.distance !== want.distance) begin
                  $error("distance: expected %0d, got %0d", want.distance,
                         rsp_payload.distance);
                  failures++;
               end
               if (rsp_payload.too_long !== want.too_long) begin
                  $error("too_long: expected %0b, got %0b", want.too_long,
                         rsp_payload.too_long);
                  failures++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct(accepted));
      end
   end

   task automatic put_item(logic op, logic [23:0] sym, logic fin);
      ede_pkg::req_payload_type t;
      t.opcode = op;
      t.symbol = sym;
      t.last   = fin;
      symbol_feed.insert(symbol_feed.size(), t);
   endtask

   // Mostly a small alphabet so that matches are common
   function automatic logic [23:0] pick_symbol();
      if ($urandom_range(99) < 70)
         return alphabet[$urandom_range(5)];
      return 24'($urandom);
   endfunction

   task automatic put_word(logic op, int len, bit closed);
      for (int k = 0; k < len; k++)
         put_item(op, pick_symbol(), closed && k == len - 1);
   endtask

   // Stimulus and end of run
   initial begin
      int qlen;
      int cut;
      int ncand;
      int clen;
      for (int k = 0; k < 6; k++)
         alphabet[k] = 24'($urandom);

      // empty query: distance is the candidate length
      put_item(ede_pkg::OP_CANDIDATE, 24'h000000, 1'b0);
      put_item(ede_pkg::OP_CANDIDATE, 24'hFFFFFF, 1'b1);
      // candidate against a query still being written, then the query goes on
      put_item(ede_pkg::OP_QUERY, 24'h000000, 1'b0);
      put_item(ede_pkg::OP_CANDIDATE, 24'h000000, 1'b1);
      put_item(ede_pkg::OP_QUERY, 24'hFFFFFF, 1'b1);
      put_item(ede_pkg::OP_CANDIDATE, 24'hFFFFFF, 1'b0);
      put_item(ede_pkg::OP_CANDIDATE, 24'h000000, 1'b1);
      put_item(ede_pkg::OP_CANDIDATE, 24'h000000, 1'b0);
      put_item(ede_pkg::OP_CANDIDATE, 24'hFFFFFF, 1'b1);
      // query symbol mid-candidate drops the candidate and starts a new query
      put_item(ede_pkg::OP_CANDIDATE, 24'h123456, 1'b0);
      put_item(ede_pkg::OP_QUERY, 24'hABCDEF, 1'b1);
      put_item(ede_pkg::OP_CANDIDATE, 24'hABCDEF, 1'b1);
      put_item(ede_pkg::OP_CANDIDATE, 24'h800000, 1'b1);
      put_item(ede_pkg::OP_CANDIDATE, 24'h7FFFFF, 1'b0);
      put_item(ede_pkg::OP_CANDIDATE, 24'hABCDEF, 1'b1);

      // overlong query, then candidates at and over the limit, two ending on a dropped symbol
      put_word(ede_pkg::OP_QUERY, 67, 1'b1);
      put_word(ede_pkg::OP_CANDIDATE, 66, 1'b1);
      put_word(ede_pkg::OP_CANDIDATE, 64, 1'b1);
      put_word(ede_pkg::OP_QUERY, 5, 1'b1);
      put_word(ede_pkg::OP_CANDIDATE, 70, 1'b1);

      // random word groups: a query and a few candidates, with some noise
      while (symbol_feed.size() < 1300) begin
         qlen = ($urandom_range(99) < 4) ? $urandom_range(60, 70)
                                         : $urandom_range(1, 10);
         if (qlen > 1 && $urandom_range(99) < 10) begin
            cut = $urandom_range(1, qlen - 1);
            put_word(ede_pkg::OP_QUERY, cut, 1'b0);
            put_word(ede_pkg::OP_CANDIDATE, $urandom_range(1, 6), 1'b1);
            put_word(ede_pkg::OP_QUERY, qlen - cut, 1'b1);
         end else begin
            put_word(ede_pkg::OP_QUERY, qlen, 1'b1);
         end
         ncand = $urandom_range(1, 6);
         for (int c = 0; c < ncand; c++) begin
            clen = ($urandom_range(99) < 4) ? $urandom_range(60, 70)
                                            : $urandom_range(1, 12);
            put_word(ede_pkg::OP_CANDIDATE, clen,
                     !(c == ncand - 1 && $urandom_range(99) < 10));
         end
         if ($urandom_range(99) < 5) begin
            for (int k = 0; k < 3; k++)
               put_item(1'($urandom_range(1)), 24'($urandom),
                        1'($urandom_range(1)));
         end
      end
      n_items = symbol_feed.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (accepted < n_items)
         @(posedge clock);
      while (pending_distances.size() != 0)
         @(posedge clock);
      // let any stray transfer show up
      repeat (100) @(posedge clock);
      if (failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog
   initial begin
      #4ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[filelist.f]
rtl/ede_pkg.sv
rtl/ede_ram.sv
rtl/ede_cell_unit.sv
rtl/edit_distance_engine.sv
rtl/ede_checker.sv
bench/tb.sv
